>>> src/bmf_pkg.sv
package bmf_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int MAX_RADIUS = 7;
	localparam int LINE_COUNT = 16;

	localparam int COL_BITS  = $clog2(MAX_WIDTH);
	localparam int LINE_BITS = $clog2(LINE_COUNT);
	localparam int ADDR_BITS = LINE_BITS + COL_BITS;
	localparam int DIM_BITS  = 11;
	localparam int RAD_BITS  = 3;
	localparam int CNT_BITS  = 21;
	localparam int SUM_BITS  = 16;
	localparam int NUM_BITS  = 17;
	localparam int DEN_BITS  = 9;
	localparam int POS_BITS  = 13;

	// radius limit from the line store depth and the radius range
	localparam int R_LINE = (LINE_COUNT - 2) / 2;
	localparam int R_CAP  = (MAX_RADIUS < R_LINE) ? MAX_RADIUS : R_LINE;

	// register indexes
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_RADIUS = 2'd2;

	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_DRAIN = 1'b1;

	typedef logic [ADDR_BITS-1:0] mem_addr_t;

	// reflect-101 about the frame borders
	function automatic logic [COL_BITS-1:0] reflect101(
		input logic signed [POS_BITS-1:0] i,
		input logic [DIM_BITS-1:0] n
	);
		logic signed [POS_BITS-1:0] v;
		logic signed [POS_BITS-1:0] ns;
		ns = $signed({{(POS_BITS-DIM_BITS){1'b0}}, n});
		v = i;
		if (v < 0) v = -v;
		if (v >= ns) v = POS_BITS'(2 * (ns - 1) - v);
		if (v < 0) v = '0;
		if (v >= ns) v = POS_BITS'(ns - 1);
		return v[COL_BITS-1:0];
	endfunction

endpackage

>>> src/bmf_req_if.sv
interface bmf_req_if;
	logic valid;
	logic ready;
	logic req_type;
	logic [7:0] pixel_in;
	modport source (output valid, req_type, pixel_in, input ready);
	modport sink (input valid, req_type, pixel_in, output ready);
endinterface

>>> src/bmf_rsp_if.sv
interface bmf_rsp_if;
	logic valid;
	logic ready;
	logic [7:0] pixel_out;
	logic frame_done;
	modport source (output valid, pixel_out, frame_done, input ready);
	modport sink (input valid, pixel_out, frame_done, output ready);
endinterface

>>> src/bmf_cfg_if.sv
interface bmf_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [10:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> src/box_mean_filter_reflect_edges_top.sv
// Box mean filter, (2r+1) square window, reflect-101 borders, 8-bit pixels.
// req: raster pixels (req_type 0) or drain ticks (req_type 1).
// rsp: rounded window mean and frame_done on the last pixel of a frame.
// cfg: register writes (0 width, 1 height, 2 radius); always ready, each
// write to these three restarts the frame. Radius is clamped to 7 and to min(W,H)-1.
// Results lag the input by r rows plus r pixels; drain ticks flush the tail.
// For an item that yields a result, every window pixel is fetched from the
// single read port of the line store, then an 8-step shift-subtract divider
// forms the rounded mean. An item without a result leaves the input ready
// for the next item.
// A new item is taken while a finished result waits in the output register;
// if the receiver stalls, the next result waits in the divider until the
// output register frees, and input stops meanwhile.
// Reset: width 1024, height 1024, radius 1, frame position zero, no result
// pending; the line store needs no clearing.
module box_mean_filter_reflect_edges_top
	import bmf_pkg::*;
(
	input logic clk,
	input logic arst_n,
	bmf_req_if.sink   req,
	bmf_rsp_if.source rsp,
	bmf_cfg_if.sink   cfg
);
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_FLUSH = 3'd2;
	localparam logic [2:0] ST_START = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;

	logic [2:0] state_q;
	logic [DIM_BITS-1:0] width_q, height_q;
	logic [RAD_BITS-1:0] radius_q;
	logic [DIM_BITS-1:0] w, h, mn;
	logic [RAD_BITS-1:0] r, r1;
	logic [CNT_BITS-1:0] total;
	logic [CNT_BITS:0] lag_sum;

	logic [DIM_BITS-1:0] in_row_q;
	logic [COL_BITS-1:0] in_col_q;
	logic [CNT_BITS-1:0] in_cnt_q, oi_q;
	logic [COL_BITS-1:0] orow_q, ocol_q;

	logic [COL_BITS-1:0] oy_q, ox_q;
	logic [DIM_BITS-1:0] wr_q, hr_q;
	logic [RAD_BITS-1:0] rr_q;
	logic signed [RAD_BITS:0] dy_q, dx_q, rs;
	logic fd_q;
	logic [SUM_BITS-1:0] acc_q;
	logic rd_vld_s1;

	logic accept, all_in, pix, emit, last;
	logic [CNT_BITS-1:0] in_cnt_nx;
	logic [COL_BITS-1:0] row_sel, col_sel;
	mem_addr_t raddr, waddr;
	logic [7:0] rdata;
	logic [3:0] side;
	logic [7:0] n_win;
	logic div_busy;
	logic [7:0] quot;
	logic out_free;
	logic out_valid_q;
	logic [7:0] pix_q;
	logic done_q;

	// effective geometry
	always_comb begin
		w = (width_q == '0) ? DIM_BITS'(1) :
			((width_q > DIM_BITS'(MAX_WIDTH)) ? DIM_BITS'(MAX_WIDTH) : width_q);
		h = (height_q == '0) ? DIM_BITS'(1) :
			((height_q > DIM_BITS'(MAX_HEIGHT)) ? DIM_BITS'(MAX_HEIGHT) : height_q);
		mn = ((w < h) ? w : h) - DIM_BITS'(1);
		r1 = (radius_q > RAD_BITS'(R_CAP)) ? RAD_BITS'(R_CAP) : radius_q;
		r = ({{(DIM_BITS-RAD_BITS){1'b0}}, r1} > mn) ? mn[RAD_BITS-1:0] : r1;
		total = CNT_BITS'(w * h);
		lag_sum = {1'b0, oi_q} + (CNT_BITS+1)'(r * w) + (CNT_BITS+1)'(r);
	end

	// item decision
	assign accept = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign all_in = (in_row_q >= h);
	assign pix = (req.req_type == REQ_PIXEL) && !all_in;
	assign in_cnt_nx = in_cnt_q + CNT_BITS'(1);
	always_comb begin
		if (pix) emit = (oi_q < total) && ({1'b0, in_cnt_nx} > lag_sum);
		else emit = all_in && (oi_q < total);
	end
	assign waddr = {in_row_q[LINE_BITS-1:0], in_col_q};
	assign cfg.ready = 1'b1;

	// frame counters and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_BITS'(MAX_WIDTH);
			height_q <= DIM_BITS'(MAX_HEIGHT);
			radius_q <= RAD_BITS'(1);
			in_row_q <= '0;
			in_col_q <= '0;
			in_cnt_q <= '0;
			oi_q     <= '0;
			orow_q   <= '0;
			ocol_q   <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_WIDTH:  width_q  <= cfg.data;
				REG_HEIGHT: height_q <= cfg.data;
				REG_RADIUS: radius_q <= cfg.data[RAD_BITS-1:0];
				default: ;
			endcase
			if ((cfg.index == REG_WIDTH) || (cfg.index == REG_HEIGHT) ||
				(cfg.index == REG_RADIUS)) begin
				in_row_q <= '0;
				in_col_q <= '0;
				in_cnt_q <= '0;
				oi_q     <= '0;
				orow_q   <= '0;
				ocol_q   <= '0;
			end
		end else if (accept) begin
			if (emit && (oi_q + CNT_BITS'(1) >= total)) begin
				in_row_q <= '0;
				in_col_q <= '0;
				in_cnt_q <= '0;
				oi_q     <= '0;
				orow_q   <= '0;
				ocol_q   <= '0;
			end else begin
				if (pix) begin
					in_cnt_q <= in_cnt_nx;
					if ({1'b0, in_col_q} + DIM_BITS'(1) >= w) begin
						in_col_q <= '0;
						in_row_q <= in_row_q + DIM_BITS'(1);
					end else begin
						in_col_q <= in_col_q + COL_BITS'(1);
					end
				end
				if (emit) begin
					oi_q <= oi_q + CNT_BITS'(1);
					if ({1'b0, ocol_q} + DIM_BITS'(1) >= w) begin
						ocol_q <= '0;
						orow_q <= orow_q + COL_BITS'(1);
					end else begin
						ocol_q <= ocol_q + COL_BITS'(1);
					end
				end
			end
		end
	end

	// window position snapshot
	always_ff @(posedge clk) begin
		if (accept && emit) begin
			oy_q <= orow_q;
			ox_q <= ocol_q;
			wr_q <= w;
			hr_q <= h;
			rr_q <= r;
			fd_q <= (oi_q + CNT_BITS'(1) >= total);
		end
	end

	// window scan address
	assign rs = $signed({1'b0, rr_q});
	assign last = (dy_q == rs) && (dx_q == rs);
	always_comb begin
		row_sel = reflect101($signed({{(POS_BITS-COL_BITS){1'b0}}, oy_q})
			+ POS_BITS'(dy_q), hr_q);
		col_sel = reflect101($signed({{(POS_BITS-COL_BITS){1'b0}}, ox_q})
			+ POS_BITS'(dx_q), wr_q);
		raddr = {row_sel[LINE_BITS-1:0], col_sel};
	end

	bmf_line_mem u_mem (
		.clk   (clk),
		.we    (accept && pix),
		.waddr (waddr),
		.wdata (req.pixel_in),
		.re    (state_q == ST_SCAN),
		.raddr (raddr),
		.rdata (rdata)
	);

	// rounding divide: (2*sum + n) / (2*n)
	assign side = {rr_q, 1'b1};
	assign n_win = side * side;
	bmf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_START),
		.num    ({acc_q, 1'b0} + NUM_BITS'(n_win)),
		.den    ({n_win, 1'b0}),
		.busy   (div_busy),
		.quot   (quot)
	);

	assign out_free = !out_valid_q || rsp.ready;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rd_vld_s1 <= 1'b0;
			dy_q      <= '0;
			dx_q      <= '0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN);
			unique case (state_q)
				ST_IDLE: begin
					if (accept && emit) begin
						state_q <= ST_SCAN;
						dy_q <= -$signed({1'b0, r});
						dx_q <= -$signed({1'b0, r});
					end
				end
				ST_SCAN: begin
					if (last) begin
						state_q <= ST_FLUSH;
					end else if (dx_q == rs) begin
						dx_q <= -rs;
						dy_q <= dy_q + $signed((RAD_BITS+1)'(1));
					end else begin
						dx_q <= dx_q + $signed((RAD_BITS+1)'(1));
					end
				end
				ST_FLUSH: state_q <= ST_START;
				ST_START: state_q <= ST_DIV;
				ST_DIV: begin
					if (!div_busy && out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// window sum
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) acc_q <= '0;
		else if (rd_vld_s1) acc_q <= acc_q + SUM_BITS'(rdata);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DIV && !div_busy && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DIV && !div_busy && out_free) begin
			pix_q  <= quot;
			done_q <= fd_q;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.pixel_out  = pix_q;
	assign rsp.frame_done = done_q;
endmodule

>>> src/bmf_line_mem.sv
module bmf_line_mem
	import bmf_pkg::*;
(
	input  logic      clk,
	input  logic      we,
	input  mem_addr_t waddr,
	input  logic [7:0] wdata,
	input  logic      re,
	input  mem_addr_t raddr,
	output logic [7:0] rdata
);
	logic [7:0] mem [LINE_COUNT*MAX_WIDTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end
endmodule

>>> src/bmf_div.sv
module bmf_div
	import bmf_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [NUM_BITS-1:0] num,
	input  logic [DEN_BITS-1:0] den,
	output logic                busy,
	output logic [7:0]          quot
);
	logic [NUM_BITS:0] rem_q;
	logic [DEN_BITS-1:0] den_q;
	logic [2:0] k_q;
	logic [NUM_BITS+DEN_BITS:0] trial;

	assign trial = {{(NUM_BITS+1){1'b0}}, den_q} << k_q;

	// one quotient bit per cycle, msb first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy <= 1'b0;
			k_q  <= '0;
		end else if (start) begin
			busy <= 1'b1;
			k_q  <= 3'd7;
		end else if (busy) begin
			if (k_q == 3'd0) busy <= 1'b0;
			k_q <= k_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
			quot  <= '0;
		end else if (busy) begin
			if ({{DEN_BITS{1'b0}}, rem_q} >= trial) begin
				rem_q <= rem_q - trial[NUM_BITS:0];
				quot[k_q] <= 1'b1;
			end
		end
	end
endmodule

>>> src/bmf_checker.sv
module bmf_checker
	import bmf_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic [7:0] rsp_pixel,
	input logic rsp_done,
	input logic cfg_valid,
	input logic cfg_ready
);
	// stalled beat stays
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("rsp beat dropped under stall");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_pixel) && $stable(rsp_done))
		else $error("rsp payload changed under stall");

	// config port never stalls
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("cfg write stalled");

	// a result needs at least the window fetch and the divide
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !$rose(rsp_valid))
		else $error("result too early after input beat");
endmodule

bind box_mean_filter_reflect_edges_top bmf_checker u_bmf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_pixel (rsp.pixel_out),
	.rsp_done  (rsp.frame_done),
	.cfg_valid (cfg.valid),
	.cfg_ready (cfg.ready)
);
